// ----- sv/xsr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsr_pkg
// shared types, constants and jump polynomial tables of the xoshiro256**
// generator
// ----------------------------------------------------------------------------
package xsr_pkg;

  localparam logic [63:0] SM_GAMMA = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] SM_MUL1  = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] SM_MUL2  = 64'h94d049bb133111eb;

  localparam logic [63:0] JUMP_POLY [4] = '{
    64'h180ec6d33cfd0aba, 64'hd5a61266f0c9392c,
    64'ha9582618e03fc9aa, 64'h39abdc4529b1661c
  };

  localparam logic [63:0] LONG_JUMP_POLY [4] = '{
    64'h76e15d3efefdcbbf, 64'hc5004e441c522fb3,
    64'h77710069854ee241, 64'h39109bb02acbe635
  };

  typedef enum logic [1:0] {
    CMD_NEXT      = 2'd0,
    CMD_SEED      = 2'd1,
    CMD_JUMP      = 2'd2,
    CMD_LONG_JUMP = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NXT_OUT,
    ST_SM_ADD,
    ST_SM_MUL1,
    ST_SM_X2,
    ST_SM_MUL2,
    ST_SM_X3,
    ST_SM_CHK,
    ST_JUMP,
    ST_JUMP_COMMIT
  } state_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_NEXT,
    DP_OUT,
    DP_SEED_LOAD,
    DP_SM_ADD,
    DP_MUL,
    DP_XS27,
    DP_STORE,
    DP_JUMP_STEP,
    DP_JUMP_COMMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] word;
    logic [1:0] step;
    logic       mul_sel;
    logic       poly_bit;
    logic       first;
  } dp_cmd_t;

  typedef struct packed {
    logic any_nonzero;
  } dp_status_t;

  function automatic logic poly_bit(input logic long_sel, input logic [7:0] idx);
    logic [63:0] w;
    w = long_sel ? LONG_JUMP_POLY[idx[7:6]] : JUMP_POLY[idx[7:6]];
    return w[idx[5:0]];
  endfunction

endpackage

// ----- sv/xoshiro256ss_generator.sv -----
`timescale 1ns / 1ps
// next: s[1]*5 is registered, then the output register once the output slot is free; no new command is taken until then
// seed: splitmix64 expansion into the four state words (3-step 32x32 multiplier, 2 per word)
// jump / long jump: one state advance per polynomial bit
// a waiting result is held in the output register while the next transaction runs
// reset: seeding of seed zero, input not ready until it completes
// ----------------------------------------------------------------------------
// xoshiro256ss_generator
// xoshiro256** generator with splitmix64 seeding and jump commands
// ----------------------------------------------------------------------------
module xoshiro256ss_generator
  import xsr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [63:0] seed_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] random_value_o
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  xsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  xsr_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .seed_value_i   (seed_value_i),
    .status_o       (dp_status),
    .random_value_o (random_value_o)
  );

endmodule

// ----- sv/xsr_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsr_datapath
// state words, splitmix64 seeding with a shared 32x32 multiplier, state
// advance, jump accumulator and output register
// ----------------------------------------------------------------------------
module xsr_datapath
  import xsr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  input  logic [63:0] seed_value_i,
  output dp_status_t  status_o,
  output logic [63:0] random_value_o
);

  logic [63:0] gen_q [4];
  logic [63:0] gen_d [4];
  logic [63:0] acc_q [4];
  logic [63:0] acc_d [4];
  logic [63:0] adv   [4];
  logic [63:0] seed_q, seed_d;
  logic [63:0] z_q, z_d;
  logic [63:0] prod_q, prod_d;
  logic [63:0] tmp_q, tmp_d;
  logic [63:0] out_q, out_d;
  logic [63:0] any_q, any_d;
  logic [63:0] sm_sum;
  logic [63:0] sm_val;
  logic [63:0] rot_tmp;
  logic [63:0] mul_const;
  logic [31:0] mul_a, mul_b;
  logic [63:0] pp;
  logic [63:0] t17;

  // one xoshiro256** step
  always_comb begin
    t17    = gen_q[1] << 17;
    adv[2] = gen_q[2] ^ gen_q[0];
    adv[3] = gen_q[3] ^ gen_q[1];
    adv[1] = gen_q[1] ^ adv[2];
    adv[0] = gen_q[0] ^ adv[3];
    adv[2] = adv[2] ^ t17;
    adv[3] = {adv[3][18:0], adv[3][63:19]};
  end

  assign sm_sum  = seed_q + SM_GAMMA;
  assign sm_val  = prod_q ^ (prod_q >> 31);
  assign rot_tmp = {tmp_q[56:0], tmp_q[63:57]};

  // modulo 2^64 product by a constant, one 32x32 partial product per step
  always_comb begin
    mul_const = cmd_i.mul_sel ? SM_MUL2 : SM_MUL1;
    unique case (cmd_i.step)
      2'd0: begin
        mul_a = z_q[31:0];
        mul_b = mul_const[31:0];
      end
      2'd1: begin
        mul_a = z_q[31:0];
        mul_b = mul_const[63:32];
      end
      default: begin
        mul_a = z_q[63:32];
        mul_b = mul_const[31:0];
      end
    endcase
    pp = mul_a * mul_b;
  end

  always_comb begin
    gen_d  = gen_q;
    acc_d  = acc_q;
    seed_d = seed_q;
    z_d    = z_q;
    prod_d = prod_q;
    tmp_d  = tmp_q;
    out_d  = out_q;
    any_d  = any_q;
    unique case (cmd_i.op)
      DP_NEXT: begin
        tmp_d = gen_q[1] + (gen_q[1] << 2);
        gen_d = adv;
      end
      DP_OUT: begin
        out_d = rot_tmp + (rot_tmp << 3);
      end
      DP_SEED_LOAD: begin
        seed_d = seed_value_i;
      end
      DP_SM_ADD: begin
        seed_d = sm_sum;
        z_d    = sm_sum ^ (sm_sum >> 30);
      end
      DP_MUL: begin
        if (cmd_i.step == 2'd0) begin
          prod_d = pp;
        end else begin
          prod_d = prod_q + {pp[31:0], 32'd0};
        end
      end
      DP_XS27: begin
        z_d = prod_q ^ (prod_q >> 27);
      end
      DP_STORE: begin
        gen_d[cmd_i.word] = sm_val;
        any_d = (cmd_i.word == 2'd0) ? sm_val : (any_q | sm_val);
      end
      DP_JUMP_STEP: begin
        for (int w = 0; w < 4; w++) begin
          acc_d[w] = (cmd_i.first ? 64'd0 : acc_q[w]) ^
                     (cmd_i.poly_bit ? gen_q[w] : 64'd0);
        end
        gen_d = adv;
      end
      DP_JUMP_COMMIT: begin
        gen_d = acc_q;
      end
      default: begin
      end
    endcase
  end

  // seeding after reset starts from seed zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= 64'd0;
    end else begin
      seed_q <= seed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gen_q  <= gen_d;
    acc_q  <= acc_d;
    z_q    <= z_d;
    prod_q <= prod_d;
    tmp_q  <= tmp_d;
    out_q  <= out_d;
    any_q  <= any_d;
  end

  assign status_o.any_nonzero = |any_q;
  assign random_value_o       = out_q;

endmodule

// ----- sv/xsr_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsr_ctrl
// command sequencer: handshakes, seeding rounds, multiply steps and the
// 256-step jump walk
// ----------------------------------------------------------------------------
module xsr_ctrl
  import xsr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] command_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e     state_q, state_d;
  logic [1:0] word_q, word_d;
  logic [1:0] round_q, round_d;
  logic [1:0] step_q, step_d;
  logic [7:0] idx_q, idx_d;
  logic       long_q, long_d;
  logic       out_valid_q, out_valid_d;
  cmd_e       cmd;

  assign cmd = cmd_e'(command_i);

  always_comb begin
    state_d     = state_q;
    word_d      = word_q;
    round_d     = round_q;
    step_d      = step_q;
    idx_d       = idx_q;
    long_d      = long_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    in_ready_o  = 1'b0;

    cmd_o          = '0;
    cmd_o.op       = DP_NOP;
    cmd_o.word     = word_q;
    cmd_o.step     = step_q;
    cmd_o.poly_bit = poly_bit(long_q, idx_q);
    cmd_o.first    = (idx_q == 8'd0);

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (cmd)
            CMD_NEXT: begin
              cmd_o.op = DP_NEXT;
              state_d  = ST_NXT_OUT;
            end
            CMD_SEED: begin
              cmd_o.op = DP_SEED_LOAD;
              word_d   = 2'd0;
              round_d  = 2'd0;
              state_d  = ST_SM_ADD;
            end
            default: begin
              long_d  = (cmd == CMD_LONG_JUMP);
              idx_d   = 8'd0;
              state_d = ST_JUMP;
            end
          endcase
        end
      end
      ST_NXT_OUT: begin
        // wait for the output slot to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = DP_OUT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_SM_ADD: begin
        cmd_o.op = DP_SM_ADD;
        step_d   = 2'd0;
        state_d  = ST_SM_MUL1;
      end
      ST_SM_MUL1, ST_SM_MUL2: begin
        cmd_o.op      = DP_MUL;
        cmd_o.mul_sel = (state_q == ST_SM_MUL2);
        if (step_q == 2'd2) begin
          step_d  = 2'd0;
          state_d = (state_q == ST_SM_MUL1) ? ST_SM_X2 : ST_SM_X3;
        end else begin
          step_d = step_q + 2'd1;
        end
      end
      ST_SM_X2: begin
        cmd_o.op = DP_XS27;
        state_d  = ST_SM_MUL2;
      end
      ST_SM_X3: begin
        cmd_o.op = DP_STORE;
        if (word_q == 2'd3) begin
          state_d = ST_SM_CHK;
        end else begin
          word_d  = word_q + 2'd1;
          state_d = ST_SM_ADD;
        end
      end
      ST_SM_CHK: begin
        // an all-zero expansion repeats, at most four rounds in total
        if (status_i.any_nonzero || round_q == 2'd3) begin
          state_d = ST_IDLE;
        end else begin
          round_d = round_q + 2'd1;
          word_d  = 2'd0;
          state_d = ST_SM_ADD;
        end
      end
      ST_JUMP: begin
        cmd_o.op = DP_JUMP_STEP;
        idx_d    = idx_q + 8'd1;
        if (idx_q == 8'd255) begin
          state_d = ST_JUMP_COMMIT;
        end
      end
      ST_JUMP_COMMIT: begin
        cmd_o.op = DP_JUMP_COMMIT;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // reset runs the seeding sequence for seed zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SM_ADD;
      word_q      <= 2'd0;
      round_q     <= 2'd0;
      step_q      <= 2'd0;
      idx_q       <= 8'd0;
      long_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      word_q      <= word_d;
      round_q     <= round_d;
      step_q      <= step_d;
      idx_q       <= idx_d;
      long_q      <= long_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
